// ===== design/vertex_project_to_screen_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the vertex projection core
// Shared clocked assertion forms with the reset taken into account.
// ---------------------------------------------------------------------------
`ifndef VERTEX_PROJECT_TO_SCREEN_CORE_ASSERT_SVH
`define VERTEX_PROJECT_TO_SCREEN_CORE_ASSERT_SVH

// An implication that must hold in the same cycle.
`define VPTS_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// An implication that must hold in the following cycle.
`define VPTS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/vpts_pkg.sv =====
// ---------------------------------------------------------------------------
// vpts_pkg
// Types, constants and helpers shared by the vertex projection core.
// ---------------------------------------------------------------------------
package vpts_pkg;

    localparam int NUM_REGS     = 8;
    localparam int REG_IDX_W    = 3;
    localparam int REG_W        = 64;
    localparam int DIM_W        = 13;     // holds screen sizes up to 8191
    localparam int Q_W          = 32;     // quotient bits produced per divide
    localparam int DEN_W        = 33;     // divisor width (twice w needs 33 bits)
    localparam int ACC_W        = 51;     // exact sum of three products and an offset
    localparam int DIV_LAT      = Q_W + 2;
    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth;
    } screen_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
    } clip_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== design/vpts_mac.sv =====
// ---------------------------------------------------------------------------
// vpts_mac
// Matrix times point: twelve registered products, then floored row sums.
// ---------------------------------------------------------------------------
module vpts_mac (
    input  logic           clk,
    input  logic           en,
    input  vpts_pkg::mat_t  mat,
    input  vpts_pkg::point_t point,
    output vpts_pkg::clip_t clip
);
    import vpts_pkg::*;

    logic signed [31:0] ent [4][4];
    logic signed [31:0] pin [3];
    logic signed [63:0] prod_reg [4][3];
    logic signed [ACC_W-1:0] acc [4];
    clip_t clip_reg;
    clip_t clip_next;

    assign pin[0] = point.point_x;
    assign pin[1] = point.point_y;
    assign pin[2] = point.point_z;

    // Even columns sit in the low half of a register, odd columns in the high half.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (c % 2 == 0)
                    ent[r][c] = mat[r*2 + c/2][31:0];
                else
                    ent[r][c] = mat[r*2 + c/2][63:32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= ent[r][c] * pin[c];
        end
    end

    // An arithmetic shift right rounds toward minus infinity.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            acc[r] = ACC_W'(ent[r][3]);
            for (int c = 0; c < 3; c++)
                acc[r] = acc[r] + ACC_W'(prod_reg[r][c] >>> 16);
        end
        clip_next.cx = sat32(acc[0]);
        clip_next.cy = sat32(acc[1]);
        clip_next.cz = sat32(acc[2]);
        clip_next.cw = sat32(acc[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            clip_reg <= clip_next;
    end

    assign clip = clip_reg;

endmodule

// ===== design/vpts_div.sv =====
// ---------------------------------------------------------------------------
// vpts_div
// Pipelined restoring divider, one quotient bit per stage, signed saturation.
// ---------------------------------------------------------------------------
module vpts_div #(
    parameter int DEN_BITS = vpts_pkg::DEN_W
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [DEN_BITS+vpts_pkg::Q_W-1:0] num,
    input  logic [DEN_BITS-1:0]          den,
    input  logic                         neg,
    input  logic                         kill,
    output logic signed [31:0]           quo
);
    import vpts_pkg::*;

    localparam int EXT_W = DEN_BITS + Q_W;

    logic [EXT_W-1:0]    rem_reg  [0:Q_W-1];
    logic [DEN_BITS-1:0] den_reg  [0:Q_W-1];
    logic [Q_W-1:0]      q_reg    [0:Q_W];
    logic                ovf_reg  [0:Q_W];
    logic                neg_reg  [0:Q_W];
    logic                kill_reg [0:Q_W];
    logic signed [31:0]  quo_reg;
    logic signed [31:0]  quo_next;

    // A quotient that cannot fit in the stage count is flagged up front.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= num >= {den, {Q_W{1'b0}}};
            neg_reg[0]  <= neg;
            kill_reg[0] <= kill;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [EXT_W-1:0] sh;
        logic             ge;

        assign sh = {{Q_W{1'b0}}, den_reg[k]} << (Q_W - 1 - k);
        assign ge = rem_reg[k] >= sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]    <= q_reg[k] | (Q_W'(ge) << (Q_W - 1 - k));
                ovf_reg[k+1]  <= ovf_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                kill_reg[k+1] <= kill_reg[k];
            end
        end

        if (k < Q_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? rem_reg[k] - sh : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    always_comb
    begin
        if (kill_reg[Q_W])
            quo_next = '0;
        else if (neg_reg[Q_W])
        begin
            if (ovf_reg[Q_W] || (q_reg[Q_W][Q_W-1] && (|q_reg[Q_W][Q_W-2:0])))
                quo_next = 32'sh8000_0000;
            else
                quo_next = -$signed(q_reg[Q_W]);
        end
        else if (ovf_reg[Q_W] || q_reg[Q_W][Q_W-1])
            quo_next = 32'sh7FFF_FFFF;
        else
            quo_next = $signed(q_reg[Q_W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// ===== design/vertex_project_to_screen_core.sv =====
// ---------------------------------------------------------------------------
// vertex_project_to_screen_core
// Projects a world point through a 4x4 matrix to screen pixels and depth.
// ---------------------------------------------------------------------------
// Channel  | Direction | Handshake                 | Payload
// point    | in        | point_valid / point_stall | point_t (x, y, z)
// screen   | out       | screen_valid / screen_stall | screen_t
// config   | in        | APB psel / penable        | 64-bit matrix registers
//
// One item is accepted every cycle unless a held result stalls the input side.
// Most stages belong to the three dividers, which produce one quotient bit per stage.
// The whole pipeline advances together; a held result stalls the input side.
// Reset loads the identity matrix and empties the pipeline.
// ---------------------------------------------------------------------------
module vertex_project_to_screen_core #(
    parameter int SCREEN_WIDTH  = vpts_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = vpts_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              point_valid,
    output logic              point_stall,
    input  vpts_pkg::point_t  point,
    output logic              screen_valid,
    input  logic              screen_stall,
    output vpts_pkg::screen_t screen
);
    import vpts_pkg::*;

    localparam int PIPE_LEN = 4 + DIV_LAT;

    mat_t                 mat_reg;
    logic                 en;
    logic                 vld_reg [0:PIPE_LEN-1];
    logic                 vis_reg [0:DIV_LAT+1];
    clip_t                clip;
    logic signed [32:0]   sum_x_reg;
    logic signed [32:0]   sum_y_reg;
    logic signed [31:0]   cz_reg;
    logic [31:0]          cw_reg;
    logic [45:0]          mag_x_reg;
    logic [45:0]          mag_y_reg;
    logic [31:0]          mag_z_reg;
    logic                 neg_x_reg;
    logic                 neg_y_reg;
    logic                 neg_z_reg;
    logic [31:0]          cw4_reg;
    logic [32:0]          abs_x;
    logic [32:0]          abs_y;
    logic [31:0]          abs_z;
    logic signed [31:0]   quo_x;
    logic signed [31:0]   quo_y;
    logic signed [31:0]   quo_z;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                mat_reg[i] <= REG_RESET[i];
        end
        else if (psel && penable && pwrite)
            mat_reg[paddr[5:3]] <= pwdata;
    end

    assign prdata = mat_reg[paddr[5:3]];
    assign pready = 1'b1;

    // The pipeline moves whenever the output register is free or being taken.
    assign en           = !vld_reg[PIPE_LEN-1] || !screen_stall;
    assign point_stall  = !en;
    assign screen_valid = vld_reg[PIPE_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LEN; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= point_valid;
            for (int i = 1; i < PIPE_LEN; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    vpts_mac u_mac (
        .clk   (clk),
        .en    (en),
        .mat   (mat_reg),
        .point (point),
        .clip  (clip)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_x_reg  <= 33'(clip.cx) + 33'(clip.cw);
            sum_y_reg  <= 33'(clip.cw) - 33'(clip.cy);
            cz_reg     <= clip.cz;
            cw_reg     <= clip.cw;
            vis_reg[0] <= !clip.cw[31] && (|clip.cw);
        end
    end

    assign abs_x = sum_x_reg[32] ? 33'(-sum_x_reg) : 33'(sum_x_reg);
    assign abs_y = sum_y_reg[32] ? 33'(-sum_y_reg) : 33'(sum_y_reg);
    assign abs_z = cz_reg[31] ? 32'(-cz_reg) : 32'(cz_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_x_reg  <= abs_x * DIM_W'(SCREEN_WIDTH);
            mag_y_reg  <= abs_y * DIM_W'(SCREEN_HEIGHT);
            mag_z_reg  <= abs_z;
            neg_x_reg  <= sum_x_reg[32];
            neg_y_reg  <= sum_y_reg[32];
            neg_z_reg  <= cz_reg[31];
            cw4_reg    <= cw_reg;
            for (int i = 1; i <= DIV_LAT + 1; i++)
                vis_reg[i] <= vis_reg[i-1];
        end
    end

    vpts_div #(.DEN_BITS(DEN_W)) u_div_x (
        .clk  (clk),
        .en   (en),
        .num  ((DEN_W+Q_W)'({mag_x_reg, 16'h0})),
        .den  ({cw4_reg, 1'b0}),
        .neg  (neg_x_reg),
        .kill (!vis_reg[1]),
        .quo  (quo_x)
    );

    vpts_div #(.DEN_BITS(DEN_W)) u_div_y (
        .clk  (clk),
        .en   (en),
        .num  ((DEN_W+Q_W)'({mag_y_reg, 16'h0})),
        .den  ({cw4_reg, 1'b0}),
        .neg  (neg_y_reg),
        .kill (!vis_reg[1]),
        .quo  (quo_y)
    );

    vpts_div #(.DEN_BITS(DEN_W)) u_div_z (
        .clk  (clk),
        .en   (en),
        .num  ((DEN_W+Q_W)'({mag_z_reg, 16'h0})),
        .den  ({1'b0, cw4_reg}),
        .neg  (neg_z_reg),
        .kill (!vis_reg[1]),
        .quo  (quo_z)
    );

    assign screen.visible  = vis_reg[DIV_LAT+1];
    assign screen.screen_x = quo_x;
    assign screen.screen_y = quo_y;
    assign screen.depth    = quo_z;

`include "vertex_project_to_screen_core_assert.svh"

    `VPTS_ASSERT_NOW(a_hidden_zero, screen_valid && !screen.visible, screen.screen_x == 0 && screen.screen_y == 0 && screen.depth == 0, "hidden point has nonzero fields")
    `VPTS_ASSERT_NOW(a_stall_link, 1'b1, point_stall == (screen_valid && screen_stall), "input stall does not follow a held result")
    `VPTS_ASSERT_NEXT(a_enter, point_valid && !point_stall, vld_reg[0], "accepted item did not enter the pipeline")

endmodule
